// ----- rtl/core/utf8_stream_sanitizer_macros.svh -----
// Assertion macros used by the checker file.
`ifndef UTF8_STREAM_SANITIZER_MACROS_SVH
`define UTF8_STREAM_SANITIZER_MACROS_SVH

// Next-cycle implication, switched off while reset is held.
`define U8SAN_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define U8SAN_ASSERT_NEXT_ALL(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) (cond) |=> (conseq)) else $error(msg);

`endif

// ----- rtl/core/u8san_pkg.sv -----
package u8san_pkg;

  // command queue between the classifier and the byte expander
  localparam int CMD_DEPTH = 4;  // power of two, pointers wrap
  localparam int CMD_AW    = $clog2(CMD_DEPTH);

  // bytes of an open multi-byte sequence that are kept back
  localparam int HELD_DEPTH = 3;

  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  // U+FFFD as UTF-8
  localparam logic [7:0] REP_B0 = 8'hEF;
  localparam logic [7:0] REP_B1 = 8'hBF;
  localparam logic [7:0] REP_B2 = 8'hBD;

  typedef logic [7:0] octet_t;

  // One command: rep_cnt replacement characters, then lit_cnt literal
  // bytes taken from lits[0] upward.
  typedef struct packed {
    logic [2:0]       rep_cnt;
    logic [2:0]       lit_cnt;
    logic [3:0][7:0]  lits;
  } cmd_t;

  // handshake between the command queue and its two users
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/core/u8san_front.sv -----
module u8san_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [7:0]        in_byte,
  input  logic              in_final,
  output logic              in_full,
  input  u8san_pkg::q_stat_t q_stat,
  output logic              cmd_push,
  output u8san_pkg::cmd_t   cmd
);
  import u8san_pkg::*;

  octet_t      held_r [HELD_DEPTH];
  logic [1:0]  held_cnt_r, held_cnt_nxt;
  logic [2:0]  seq_len_r, seq_len_nxt;

  logic        accept;
  logic        is_cont, is_plain, keep_plain;
  logic        lead2, lead3, lead4;
  logic        wr_en;
  logic [1:0]  wr_idx;

  assign in_full = q_stat.full;
  assign accept  = in_push && !q_stat.full;

  // byte classes
  assign is_cont    = (in_byte[7:6] == 2'b10);
  assign is_plain   = !in_byte[7];
  assign keep_plain = (in_byte == BYTE_TAB) || (in_byte == BYTE_LF) || (in_byte >= BYTE_SPACE);
  assign lead2      = (in_byte[7:5] == 3'b110);
  assign lead3      = (in_byte[7:4] == 4'b1110);
  assign lead4      = (in_byte[7:3] == 5'b11110);

  // build the command and the next hold state
  always_comb begin
    cmd          = '0;
    held_cnt_nxt = held_cnt_r;
    seq_len_nxt  = seq_len_r;
    wr_en        = 1'b0;
    wr_idx       = 2'd0;
    if ((held_cnt_r != 2'd0) && is_cont) begin
      if (({1'b0, held_cnt_r} + 3'd1) >= seq_len_r) begin
        // sequence complete: held bytes, then this one
        cmd.lit_cnt = {1'b0, held_cnt_r} + 3'd1;
        for (int k = 0; k < HELD_DEPTH; k++) begin
          cmd.lits[k] = (held_cnt_r > 2'(k)) ? held_r[k] : in_byte;
        end
        cmd.lits[3]  = in_byte;
        held_cnt_nxt = 2'd0;
        seq_len_nxt  = 3'd0;
      end else begin
        wr_en        = 1'b1;
        wr_idx       = held_cnt_r;
        held_cnt_nxt = held_cnt_r + 2'd1;
      end
    end else begin
      // a break flushes the hold, then the byte is taken fresh
      cmd.rep_cnt  = {1'b0, held_cnt_r};
      held_cnt_nxt = 2'd0;
      seq_len_nxt  = 3'd0;
      priority if (is_plain) begin
        cmd.lit_cnt = 3'd1;
        cmd.lits[0] = keep_plain ? in_byte : BYTE_SPACE;
      end else if (lead2 || lead3 || lead4) begin
        seq_len_nxt  = lead2 ? 3'd2 : (lead3 ? 3'd3 : 3'd4);
        held_cnt_nxt = 2'd1;
        wr_en        = 1'b1;
        wr_idx       = 2'd0;
      end else begin
        cmd.rep_cnt = cmd.rep_cnt + 3'd1;
      end
    end
    // end of stream flushes what is still held
    if (in_final && (held_cnt_nxt != 2'd0)) begin
      cmd.rep_cnt  = cmd.rep_cnt + {1'b0, held_cnt_nxt};
      held_cnt_nxt = 2'd0;
      seq_len_nxt  = 3'd0;
    end
  end

  assign cmd_push = accept && ((cmd.rep_cnt != 3'd0) || (cmd.lit_cnt != 3'd0));

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
      seq_len_r  <= 3'd0;
    end else if (accept) begin
      held_cnt_r <= held_cnt_nxt;
      seq_len_r  <= seq_len_nxt;
    end
  end

  // held bytes, no reset
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      held_r[wr_idx] <= in_byte;
    end
  end

endmodule

// ----- rtl/core/u8san_cmd_fifo.sv -----
module u8san_cmd_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  u8san_pkg::cmd_t    wdata,
  input  logic               pop,
  output u8san_pkg::cmd_t    rdata,
  output u8san_pkg::q_stat_t stat
);
  import u8san_pkg::*;

  cmd_t               mem_r [CMD_DEPTH];
  logic [CMD_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CMD_AW:0]    cnt_r;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == (CMD_AW+1)'(CMD_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/core/u8san_back.sv -----
module u8san_back (
  input  logic               clk,
  input  logic               rst_n,
  input  u8san_pkg::q_stat_t q_stat,
  input  u8san_pkg::cmd_t    q_rdata,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [7:0]         out_byte,
  output logic               out_run_end
);
  import u8san_pkg::*;

  // current command
  logic             cur_v_r, cur_v_nxt;
  logic [2:0]       rep_r, rep_nxt;
  logic [1:0]       ph_r, ph_nxt;
  logic [2:0]       lit_cnt_r, lit_cnt_nxt;
  logic [3:0][7:0]  lits_r, lits_nxt;

  // output word register
  logic             out_v_r;
  octet_t           out_byte_r;
  logic             out_end_r;

  logic             out_free, emit, last, load;
  octet_t           cur_byte;

  assign out_free = !out_v_r || out_pop;
  assign emit     = out_free && cur_v_r;
  assign last     = ((rep_r == 3'd1) && (ph_r == 2'd2) && (lit_cnt_r == 3'd0)) ||
                    ((rep_r == 3'd0) && (lit_cnt_r == 3'd1));
  assign load     = out_free && !q_stat.empty && (!cur_v_r || last);
  assign q_pop    = load;

  // byte at the head of the current command
  always_comb begin
    if (rep_r != 3'd0) begin
      unique case (ph_r)
        2'd0:    cur_byte = REP_B0;
        2'd1:    cur_byte = REP_B1;
        default: cur_byte = REP_B2;
      endcase
    end else begin
      cur_byte = lits_r[0];
    end
  end

  // step through the command, load the next one behind its last byte
  always_comb begin
    cur_v_nxt   = cur_v_r;
    rep_nxt     = rep_r;
    ph_nxt      = ph_r;
    lit_cnt_nxt = lit_cnt_r;
    lits_nxt    = lits_r;
    priority if (load) begin
      cur_v_nxt   = 1'b1;
      rep_nxt     = q_rdata.rep_cnt;
      ph_nxt      = 2'd0;
      lit_cnt_nxt = q_rdata.lit_cnt;
      lits_nxt    = q_rdata.lits;
    end else if (emit && last) begin
      cur_v_nxt = 1'b0;
    end else if (emit) begin
      if (rep_r != 3'd0) begin
        if (ph_r == 2'd2) begin
          ph_nxt  = 2'd0;
          rep_nxt = rep_r - 3'd1;
        end else begin
          ph_nxt = ph_r + 2'd1;
        end
      end else begin
        lits_nxt    = {8'h00, lits_r[3:1]};
        lit_cnt_nxt = lit_cnt_r - 3'd1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rep_r     <= rep_nxt;
    ph_r      <= ph_nxt;
    lit_cnt_r <= lit_cnt_nxt;
    lits_r    <= lits_nxt;
    if (emit) begin
      out_byte_r <= cur_byte;
      out_end_r  <= last;
    end
  end

  assign out_empty   = !out_v_r;
  assign out_byte    = out_byte_r;
  assign out_run_end = out_end_r;

endmodule

// ----- rtl/core/utf8_stream_sanitizer.sv -----
// Path: an accepted input goes through the command queue, the current command and the output register.
// Throughput: one input word per cycle while the 4-entry command queue has room; the
//   output side moves one word per cycle while the receiver pops, and one input yields 0 to 12 output words.
// Reset: synchronous, active low; clears the hold count, the command queue and the
//   output register. Held sequence bytes are not cleared.
module utf8_stream_sanitizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_byte,
  input  logic       in_final,
  output logic       in_full,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_byte,
  output logic       out_run_end
);
  import u8san_pkg::*;

  cmd_t    push_cmd, head_cmd;
  logic    cmd_push, cmd_pop;
  q_stat_t q_stat;

  // classify input words into commands
  u8san_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_byte  (in_byte),
    .in_final (in_final),
    .in_full  (in_full),
    .q_stat   (q_stat),
    .cmd_push (cmd_push),
    .cmd      (push_cmd)
  );

  // decouple the two sides
  u8san_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (push_cmd),
    .pop   (cmd_pop),
    .rdata (head_cmd),
    .stat  (q_stat)
  );

  // expand commands into output words
  u8san_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .q_rdata     (head_cmd),
    .q_pop       (cmd_pop),
    .out_pop     (out_pop),
    .out_empty   (out_empty),
    .out_byte    (out_byte),
    .out_run_end (out_run_end)
  );

endmodule

// ----- rtl/core/u8san_checker.sv -----
module u8san_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_pop,
  input logic       out_empty,
  input logic [7:0] out_byte,
  input logic       out_run_end
);
`include "utf8_stream_sanitizer_macros.svh"

  logic out_take;
  assign out_take = out_pop && !out_empty;

  // a waiting word holds until taken
  `U8SAN_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_byte) && $stable(out_run_end), "output word changed while waiting")

  // the words of one run come without gaps
  `U8SAN_ASSERT_NEXT(a_run_no_gap, out_take && !out_run_end, !out_empty, "gap inside an output run")

  // a lead byte is always followed by a continuation byte
  `U8SAN_ASSERT_NEXT(a_lead_cont, out_take && (out_byte[7:6] == 2'b11), !out_empty && (out_byte[7:6] == 2'b10), "lead byte not followed by continuation")

  // nothing to take right after reset
  `U8SAN_ASSERT_NEXT_ALL(a_rst_empty, !rst_n, out_empty, "output not empty after reset")

endmodule

bind utf8_stream_sanitizer u8san_checker u_u8san_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import u8san_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int RST_CYCLES  = 9;
  localparam int HOLD_CYCLES = 80;
  localparam int RAND_WORDS  = 370;

  // one expected output word
  typedef struct packed {
    octet_t data;
    logic   last;
  } clean_word_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_push = 1'b0;
  octet_t in_byte = '0;
  logic   in_final = 1'b0;
  logic   in_full;
  logic   out_pop = 1'b0;
  logic   out_empty;
  octet_t out_byte;
  logic   out_run_end;

  // predictor state: the open multi-byte sequence
  octet_t     seq_buf [HELD_DEPTH];
  logic [1:0] seq_held = '0;
  logic [2:0] seq_len = '0;

  clean_word_t clean_q[$];
  int          err_cnt = 0;
  int          words_sent = 0;
  int          snd_idle = 0;
  int          rcv_idle = 0;
  logic        hold_start = 1'b0;
  int          hold_left = 0;

  utf8_stream_sanitizer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_byte    (in_byte),
    .in_final   (in_final),
    .in_full    (in_full),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_byte   (out_byte),
    .out_run_end(out_run_end)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------- predictor ----------------

  task automatic expect_byte(input octet_t b);
    clean_word_t w;
    w.data = b;
    w.last = 1'b0;
    clean_q.insert(clean_q.size(), w);
  endtask

  // U+FFFD
  task automatic expect_fffd();
    expect_byte(REP_B0);
    expect_byte(REP_B1);
    expect_byte(REP_B2);
  endtask

  // one replacement per held byte, then the hold is dropped
  task automatic drop_partial();
    int k;
    for (k = 0; k < seq_held; k++) expect_fffd();
    seq_held = '0;
    seq_len  = '0;
  endtask

  // a byte seen with nothing held
  task automatic take_fresh(input octet_t b);
    if (b[7] == 1'b0) begin
      if (b == BYTE_TAB || b == BYTE_LF || b >= BYTE_SPACE) expect_byte(b);
      else expect_byte(BYTE_SPACE);
    end else begin
      if (b[7:5] == 3'b110) seq_len = 3'd2;
      else if (b[7:4] == 4'b1110) seq_len = 3'd3;
      else if (b[7:3] == 5'b11110) seq_len = 3'd4;
      if (seq_len != 0) begin
        seq_buf[0] = b;
        seq_held   = 2'd1;
      end else begin
        // stray continuation or 0xF8 and up
        expect_fffd();
      end
    end
  endtask

  task automatic predict_sanitized(input octet_t b, input logic fin);
    int n0;
    int k;
    n0 = clean_q.size();
    if (seq_held != 0) begin
      if (b[7:6] == 2'b10) begin
        if ({1'b0, seq_held} + 3'd1 >= seq_len) begin
          // sequence complete, release it whole
          for (k = 0; k < seq_held; k++) expect_byte(seq_buf[k]);
          expect_byte(b);
          seq_held = '0;
          seq_len  = '0;
        end else begin
          seq_buf[seq_held] = b;
          seq_held = seq_held + 2'd1;
        end
      end else begin
        // broken sequence: flush, then the breaking byte starts over
        drop_partial();
        take_fresh(b);
      end
    end else begin
      take_fresh(b);
    end
    // truncated at end of stream
    if (fin && seq_held != 0) drop_partial();
    if (clean_q.size() > n0) clean_q[clean_q.size() - 1].last = 1'b1;
  endtask

  // ---------------- result side ----------------

  always @(posedge clk) begin
    clean_word_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (clean_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected word: expected none, actual byte=%02h run_end=%0b",
                   $time, out_byte, out_run_end);
        end else begin
          want = clean_q.pop_front();
          if (out_byte !== want.data) begin
            err_cnt++;
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.data, out_byte);
          end
          if (out_run_end !== want.last) begin
            err_cnt++;
            $display("%0t: out_run_end mismatch: expected %0b, actual %0b",
                     $time, want.last, out_run_end);
          end
        end
      end
      // long hold-off on request, else random stalls
      out_pop <= !hold_start && hold_left == 0 && ($urandom_range(99) >= rcv_idle);
    end
  end

  // receiver hold-off, counted down in cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------- input side ----------------

  task automatic send_word(input octet_t b, input logic fin);
    if ($urandom_range(99) < snd_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < snd_idle) @(posedge clk);
    end
    in_push  <= 1'b1;
    in_byte  <= b;
    in_final <= fin;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_sanitized(b, fin);
    words_sent++;
  endtask

  // stop sending until every expected word is back
  task automatic wait_drain();
    in_push <= 1'b0;
    while (clean_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic octet_t rand_cont();
    return {2'b10, 6'($urandom_range(63))};
  endfunction

  function automatic octet_t rand_lead(input int len);
    case (len)
      2:       return {3'b110, 5'($urandom_range(31))};
      3:       return {4'b1110, 4'($urandom_range(15))};
      default: return {5'b11110, 3'($urandom_range(7))};
    endcase
  endfunction

  // ---------------- tests ----------------

  task automatic test_ascii_classes();
    send_word(8'h00, 1'b0);
    send_word(BYTE_TAB, 1'b0);
    send_word(BYTE_LF, 1'b0);
    send_word(8'h1F, 1'b0);
    send_word(BYTE_SPACE, 1'b0);
    send_word(8'h7F, 1'b1);
  endtask

  task automatic test_multibyte();
    send_word(8'hC3, 1'b0);
    send_word(8'hA9, 1'b0);
    send_word(8'hE2, 1'b0);
    send_word(8'h82, 1'b0);
    send_word(8'hAC, 1'b0);
    send_word(8'hF0, 1'b0);
    send_word(8'h9F, 1'b0);
    send_word(8'h98, 1'b0);
    send_word(8'h80, 1'b0);
  endtask

  task automatic test_invalid_bytes();
    send_word(8'h80, 1'b0);
    send_word(8'hF8, 1'b0);
    send_word(8'hFF, 1'b0);
  endtask

  task automatic test_broken_sequences();
    // lead broken by ASCII
    send_word(8'hC3, 1'b0);
    send_word(8'h41, 1'b0);
    // three held, broken by an invalid byte: twelve words
    send_word(8'hF0, 1'b0);
    send_word(8'h90, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hFF, 1'b0);
    // truncated by the end of the stream
    send_word(8'hF0, 1'b0);
    send_word(8'h90, 1'b0);
    send_word(8'h80, 1'b1);
  endtask

  task automatic test_random_stream(input int n_words);
    int stop_at;
    int r;
    int len;
    int cut;
    int k;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 25) begin
        send_word(octet_t'($urandom_range(127)), $urandom_range(99) < 4);
      end else if (r < 85) begin
        // well-formed, or cut short when r is high
        len = $urandom_range(4, 2);
        cut = (r < 75) ? len : $urandom_range(len - 1, 1);
        send_word(rand_lead(len), $urandom_range(99) < 4);
        for (k = 1; k < cut; k++) send_word(rand_cont(), $urandom_range(99) < 4);
      end else begin
        send_word(octet_t'($urandom_range(255)), $urandom_range(99) < 4);
      end
    end
  endtask

  // receiver stops for a long stretch while the sender keeps offering words
  task automatic test_backpressure();
    int k;
    snd_idle   = 0;
    rcv_idle  <= 0;
    in_push   <= 1'b0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (k = 0; k < 12; k++) begin
      send_word(8'hFF, 1'b0);
      send_word(8'hF0, 1'b0);
      send_word(rand_cont(), 1'b0);
      send_word(rand_cont(), 1'b0);
      send_word(rand_cont(), 1'b0);
    end
    wait_drain();
  endtask

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle  = 36;
    rcv_idle <= 78;
    test_ascii_classes();
    test_multibyte();
    test_invalid_bytes();
    test_broken_sequences();
    wait_drain();

    test_random_stream(RAND_WORDS / 3);
    wait_drain();

    snd_idle  = 78;
    rcv_idle <= 36;
    test_random_stream(RAND_WORDS / 3);

    test_backpressure();

    snd_idle  = 0;
    rcv_idle <= 0;
    test_random_stream(RAND_WORDS / 3);

    wait_drain();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(CLK_PERIOD * 400000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/u8san_pkg.sv
rtl/core/u8san_front.sv
rtl/core/u8san_cmd_fifo.sv
rtl/core/u8san_back.sv
rtl/core/utf8_stream_sanitizer.sv
rtl/core/u8san_checker.sv
tb/testbench.sv
